// ===== design/ceu_pkg.sv =====
// Package for the C string escape decoder: request and result payload types,
// scan state types and the character codes used by the decoder.
// No dependencies.
package ceu_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_last;
   } rsp_type;

   typedef enum logic [1:0] {
      MODE_TEXT = 2'd0,
      MODE_ESC  = 2'd1,
      MODE_OCT  = 2'd2,
      MODE_HEX  = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] value;
      logic [1:0] count;
   } scan_type;

   // Up to two result items produced by one request.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    item0;
      rsp_type    item1;
   } dec_out_type;

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_ESCAPE = 8'h1B;
   localparam logic [7:0] CHAR_LOW_N  = 8'h6E;
   localparam logic [7:0] CHAR_LOW_R  = 8'h72;
   localparam logic [7:0] CHAR_LOW_T  = 8'h74;
   localparam logic [7:0] CHAR_LOW_E  = 8'h65;
   localparam logic [7:0] CHAR_LOW_X  = 8'h78;

   localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;
   localparam logic [1:0] HEX_MAX_DIGITS = 2'd2;

   localparam scan_type SCAN_IDLE = '{mode: MODE_TEXT, value: 8'h00, count: 2'd0};

endpackage

// ===== design/ceu_decode.sv =====
// Combinational escape decoder: from the scan state and one request it forms
// the next scan state and up to two result items. Depends on ceu_pkg.
module ceu_decode (
   input  ceu_pkg::scan_type    scan,
   input  ceu_pkg::req_type     req,
   output ceu_pkg::scan_type    scan_next,
   output ceu_pkg::dec_out_type result
);

   ceu_pkg::scan_type step;
   logic [7:0]        b;
   logic              is_oct;
   logic              is_hex;
   logic [3:0]        hex_val;
   logic [7:0]        oct_acc;
   logic [7:0]        hex_acc;

   function automatic ceu_pkg::rsp_type make_item(input logic [7:0] value);
      ceu_pkg::rsp_type item;
      item.out_byte  = value;
      item.out_valid = 1'b1;
      item.out_last  = 1'b0;
      return item;
   endfunction

   assign b       = req.in_byte;
   assign is_oct  = (b >= 8'h30) && (b <= 8'h37);
   assign oct_acc = {scan.value[4:0], b[2:0]};
   assign hex_acc = {scan.value[3:0], hex_val};

   always_comb begin
      is_hex  = 1'b1;
      hex_val = 4'h0;
      if ((b >= 8'h30) && (b <= 8'h39)) begin
         hex_val = b[3:0];
      end else if (((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46))) begin
         hex_val = 4'(b[2:0] + 3'd1) + 4'd8;
      end else begin
         is_hex = 1'b0;
      end
   end

   // Next state.
   always_comb begin
      step = scan;
      unique case (scan.mode)
         ceu_pkg::MODE_TEXT: begin
            if (b == ceu_pkg::CHAR_BSLASH) begin
               step.mode = ceu_pkg::MODE_ESC;
            end
         end
         ceu_pkg::MODE_ESC: begin
            step = ceu_pkg::SCAN_IDLE;
            if (b == ceu_pkg::CHAR_LOW_X) begin
               step.mode = ceu_pkg::MODE_HEX;
            end else if (is_oct) begin
               step = '{mode: ceu_pkg::MODE_OCT, value: {5'b0, b[2:0]}, count: 2'd1};
            end
         end
         ceu_pkg::MODE_OCT: begin
            if (is_oct && (scan.count < ceu_pkg::OCT_MAX_DIGITS - 2'd1)) begin
               step = '{mode: ceu_pkg::MODE_OCT, value: oct_acc, count: scan.count + 2'd1};
            end else begin
               step = ceu_pkg::SCAN_IDLE;
               if (!is_oct && (b == ceu_pkg::CHAR_BSLASH)) begin
                  step.mode = ceu_pkg::MODE_ESC;
               end
            end
         end
         ceu_pkg::MODE_HEX: begin
            if (is_hex && (scan.count < ceu_pkg::HEX_MAX_DIGITS - 2'd1)) begin
               step = '{mode: ceu_pkg::MODE_HEX, value: hex_acc, count: scan.count + 2'd1};
            end else begin
               step = ceu_pkg::SCAN_IDLE;
               if (!is_hex && (b == ceu_pkg::CHAR_BSLASH)) begin
                  step.mode = ceu_pkg::MODE_ESC;
               end
            end
         end
      endcase
      scan_next = req.in_last ? ceu_pkg::SCAN_IDLE : step;
   end

   // Result items.
   always_comb begin
      result = '0;
      unique case (scan.mode)
         ceu_pkg::MODE_TEXT: begin
            if (b != ceu_pkg::CHAR_BSLASH) begin
               result.item0 = make_item(b);
               result.count = 2'd1;
            end
         end
         ceu_pkg::MODE_ESC: begin
            result.count = 2'd1;
            priority if (b == ceu_pkg::CHAR_NL || b == ceu_pkg::CHAR_LOW_X || is_oct) begin
               result.count = 2'd0;
            end else if (b == ceu_pkg::CHAR_LOW_N) begin
               result.item0 = make_item(ceu_pkg::CHAR_NL);
            end else if (b == ceu_pkg::CHAR_LOW_R) begin
               result.item0 = make_item(ceu_pkg::CHAR_CR);
            end else if (b == ceu_pkg::CHAR_LOW_T) begin
               result.item0 = make_item(ceu_pkg::CHAR_TAB);
            end else if (b == ceu_pkg::CHAR_LOW_E) begin
               result.item0 = make_item(ceu_pkg::CHAR_ESCAPE);
            end else begin
               result.item0 = make_item(b);
            end
         end
         ceu_pkg::MODE_OCT: begin
            if (is_oct) begin
               if (scan.count >= ceu_pkg::OCT_MAX_DIGITS - 2'd1) begin
                  result.item0 = make_item(oct_acc);
                  result.count = 2'd1;
               end
            end else begin
               result.item0 = make_item(scan.value);
               result.count = 2'd1;
               if (b != ceu_pkg::CHAR_BSLASH) begin
                  result.item1 = make_item(b);
                  result.count = 2'd2;
               end
            end
         end
         ceu_pkg::MODE_HEX: begin
            if (is_hex) begin
               if (scan.count >= ceu_pkg::HEX_MAX_DIGITS - 2'd1) begin
                  result.item0 = make_item(hex_acc);
                  result.count = 2'd1;
               end
            end else if (scan.count != 2'd0) begin
               result.item0 = make_item(scan.value);
               result.count = 2'd1;
               if (b != ceu_pkg::CHAR_BSLASH) begin
                  result.item1 = make_item(b);
                  result.count = 2'd2;
               end
            end else if (b != ceu_pkg::CHAR_BSLASH) begin
               result.item0 = make_item(b);
               result.count = 2'd1;
            end
         end
      endcase

      // At the end of a string a pending digit run is flushed and the final
      // item carries the end mark; an empty end gives a marker-only item.
      if (req.in_last) begin
         if (((step.mode == ceu_pkg::MODE_OCT) || (step.mode == ceu_pkg::MODE_HEX)) &&
             (step.count != 2'd0)) begin
            if (result.count == 2'd0) begin
               result.item0 = make_item(step.value);
               result.count = 2'd1;
            end else begin
               result.item1 = make_item(step.value);
               result.count = 2'd2;
            end
         end
         unique case (result.count)
            2'd0: begin
               result.item0 = '{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b1};
               result.count = 2'd1;
            end
            2'd1: begin
               result.item0.out_last = 1'b1;
            end
            default: begin
               result.item1.out_last = 1'b1;
            end
         endcase
      end
   end

endmodule

// ===== design/c_escape_unescaper.sv =====
// C string escape decoder, one source byte per request.
// Request channel (req_valid/req_ready/req_data): one byte of an escaped
// string, with in_last set on the final byte of each string.
// Result channel (rsp_valid/rsp_ready/rsp_data): decoded bytes, one per
// transfer; out_last marks the final result of a string, and a string whose
// last byte yields nothing closes with a marker item whose out_valid is 0.
// A request enters an input register, is decoded from there by
// ceu_decode and its zero, one or two results are written into a small
// result queue of FifoDepth entries, from which they are presented. One
// request is taken every cycle as long as the queue has room for two
// results, so throughput is one request per cycle while each request gives
// at most one result and the receiver takes one result per cycle; a request
// with two results fills two queue entries and leaves as two transfers.
// Reset empties the input register and the queue and returns the scan state
// to plain text. When the receiver stalls, the queue fills and req_ready
// drops once fewer than two entries are free.
// Depends on ceu_pkg and ceu_decode.
module c_escape_unescaper #(
   parameter int FifoDepth = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ceu_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ceu_pkg::rsp_type  rsp_data
);

   localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
   localparam int CntW = $clog2(FifoDepth + 1);

   logic                  in_vld_ff, in_vld_in;
   ceu_pkg::req_type      in_data_ff;
   ceu_pkg::scan_type     scan_ff, scan_in;
   ceu_pkg::rsp_type      queue_ff [FifoDepth];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]       fill_ff, fill_in;
   ceu_pkg::scan_type     scan_next;
   ceu_pkg::dec_out_type  dec;
   logic                  stage_fire;
   logic                  req_fire;
   logic                  pop;
   logic [1:0]            push_cnt;
   logic [PtrW-1:0]       wr_ptr_p1;

   function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
      return (p == PtrW'(FifoDepth - 1)) ? '0 : p + 1'b1;
   endfunction

   ceu_decode u_decode (
      .scan      (scan_ff),
      .req       (in_data_ff),
      .scan_next (scan_next),
      .result    (dec)
   );

   assign stage_fire = in_vld_ff && (fill_ff <= CntW'(FifoDepth - 2));
   assign req_ready  = !in_vld_ff || stage_fire;
   assign req_fire   = req_valid && req_ready;
   assign rsp_valid  = (fill_ff != '0);
   assign rsp_data   = queue_ff[rd_ptr_ff];
   assign pop        = rsp_valid && rsp_ready;
   assign push_cnt   = stage_fire ? dec.count : 2'd0;
   assign wr_ptr_p1  = ptr_inc(wr_ptr_ff);

   always_comb begin
      in_vld_in = req_fire || (in_vld_ff && !stage_fire);
      scan_in   = stage_fire ? scan_next : scan_ff;
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      unique case (push_cnt)
         2'd0:    wr_ptr_in = wr_ptr_ff;
         2'd1:    wr_ptr_in = wr_ptr_p1;
         default: wr_ptr_in = ptr_inc(wr_ptr_p1);
      endcase
      fill_in = fill_ff + CntW'(push_cnt) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         scan_ff   <= ceu_pkg::SCAN_IDLE;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         scan_ff   <= scan_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
      if (push_cnt != 2'd0) begin
         queue_ff[wr_ptr_ff] <= dec.item0;
      end
      if (push_cnt == 2'd2) begin
         queue_ff[wr_ptr_p1] <= dec.item1;
      end
   end

endmodule

// ===== design/ceu_checker.sv =====
// Port-level checker for the C string escape decoder, bound to the top level.
// Depends on ceu_pkg and c_escape_unescaper.
module ceu_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ceu_pkg::rsp_type rsp_data
);

   // A stalled result must hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // A marker-only item always closes a string and carries a zero byte.
   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_valid |-> rsp_data.out_last && (rsp_data.out_byte == 8'h00))
      else $error("malformed end marker");

   // Leaving reset, no result is pending and requests are taken.
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("block not empty after reset");

   // With the queue empty and no request accepted in this or the previous cycle,
   // nothing can reach the output in the next cycle.
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready) && !$past(req_valid && req_ready)
      |=> !rsp_valid)
      else $error("result appeared without a request");

endmodule

bind c_escape_unescaper ceu_checker u_ceu_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for c_escape_unescaper: feeds escaped strings with random
// gaps and checks every decoded byte against a built-in model of the decoder.
// Depends on ceu_pkg and the design files.
module tb_top;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_ITEMS  = 1950;
   localparam int LONG_HOLD     = 150;
   localparam int HOLD_AT_FIRST = 200;
   localparam int HOLD_AT_LATER = 1000;
   localparam int DRAIN_EVERY   = 500;
   localparam int TAIL_CYCLES   = 20;
   localparam int PRINT_LIMIT   = 100;

   localparam logic [7:0] CHR_0     = 8'h30;
   localparam logic [7:0] CHR_7     = 8'h37;
   localparam logic [7:0] CHR_9     = 8'h39;
   localparam logic [7:0] CHR_LOW_A = 8'h61;
   localparam logic [7:0] CHR_LOW_F = 8'h66;
   localparam logic [7:0] CHR_UP_A  = 8'h41;
   localparam logic [7:0] CHR_UP_F  = 8'h46;

   typedef struct {
      ceu_pkg::req_type req;
      int unsigned      gap_after;
      bit               wait_drain;
   } feed_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ceu_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ceu_pkg::rsp_type rsp_data;

   feed_type          pending_requests[$];
   ceu_pkg::rsp_type  expected_chars[$];
   ceu_pkg::rsp_type  decoded_now[$];
   logic [7:0]        str_buf[$];
   bit                drain_next;
   int                fail_count;
   int                results_taken;
   int                cycle_count;
   int                gap_left;
   int                stall_left;

   // Decoder state as seen by the checker.
   ceu_pkg::mode_type scan_state;
   logic [7:0]        digits_value;
   logic [1:0]        digits_seen;

   c_escape_unescaper i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task report_fault(input string what);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) begin
         $display("%0t: %s", $time, what);
      end
   endtask

   function void emit_char(input logic [7:0] b);
      ceu_pkg::rsp_type item;
      item.out_byte  = b;
      item.out_valid = 1'b1;
      item.out_last  = 1'b0;
      decoded_now.push_back(item);
   endfunction

   function void take_text(input logic [7:0] b);
      if (b == ceu_pkg::CHAR_BSLASH) begin
         scan_state = ceu_pkg::MODE_ESC;
      end else begin
         emit_char(b);
      end
   endfunction

   function void start_run(input ceu_pkg::mode_type m, input logic [7:0] v,
                           input logic [1:0] c);
      scan_state   = m;
      digits_value = v;
      digits_seen  = c;
   endfunction

   function int hex_weight(input logic [7:0] b);
      if (b >= CHR_0 && b <= CHR_9) return int'(b - CHR_0);
      if (b >= CHR_LOW_A && b <= CHR_LOW_F) return int'(b - CHR_LOW_A) + 10;
      if (b >= CHR_UP_A && b <= CHR_UP_F) return int'(b - CHR_UP_A) + 10;
      return -1;
   endfunction

   function void decode_request(input ceu_pkg::req_type r);
      logic [7:0]       b;
      int               h;
      ceu_pkg::rsp_type marker;
      b = r.in_byte;
      decoded_now.delete();
      case (scan_state)
         ceu_pkg::MODE_TEXT: begin
            take_text(b);
         end
         ceu_pkg::MODE_ESC: begin
            scan_state = ceu_pkg::MODE_TEXT;
            case (b)
               ceu_pkg::CHAR_DQUOTE: emit_char(ceu_pkg::CHAR_DQUOTE);
               ceu_pkg::CHAR_NL:     ;
               ceu_pkg::CHAR_LOW_N:  emit_char(ceu_pkg::CHAR_NL);
               ceu_pkg::CHAR_LOW_R:  emit_char(ceu_pkg::CHAR_CR);
               ceu_pkg::CHAR_LOW_T:  emit_char(ceu_pkg::CHAR_TAB);
               ceu_pkg::CHAR_LOW_E:  emit_char(ceu_pkg::CHAR_ESCAPE);
               ceu_pkg::CHAR_LOW_X:  start_run(ceu_pkg::MODE_HEX, 8'h00, 2'd0);
               default: begin
                  if (b >= CHR_0 && b <= CHR_7) begin
                     start_run(ceu_pkg::MODE_OCT, b - CHR_0, 2'd1);
                  end else begin
                     emit_char(b);
                  end
               end
            endcase
         end
         ceu_pkg::MODE_OCT: begin
            if (b >= CHR_0 && b <= CHR_7) begin
               digits_value = (digits_value << 3) | (b - CHR_0);
               digits_seen  = digits_seen + 2'd1;
               if (digits_seen >= ceu_pkg::OCT_MAX_DIGITS) begin
                  emit_char(digits_value);
                  start_run(ceu_pkg::MODE_TEXT, 8'h00, 2'd0);
               end
            end else begin
               emit_char(digits_value);
               start_run(ceu_pkg::MODE_TEXT, 8'h00, 2'd0);
               take_text(b);
            end
         end
         default: begin
            h = hex_weight(b);
            if (h >= 0) begin
               digits_value = (digits_value << 4) | 8'(h);
               digits_seen  = digits_seen + 2'd1;
               if (digits_seen >= ceu_pkg::HEX_MAX_DIGITS) begin
                  emit_char(digits_value);
                  start_run(ceu_pkg::MODE_TEXT, 8'h00, 2'd0);
               end
            end else begin
               if (digits_seen != 2'd0) begin
                  emit_char(digits_value);
               end
               start_run(ceu_pkg::MODE_TEXT, 8'h00, 2'd0);
               take_text(b);
            end
         end
      endcase
      if (r.in_last) begin
         // A digit run still open at the end of the string is flushed.
         if ((scan_state == ceu_pkg::MODE_OCT || scan_state == ceu_pkg::MODE_HEX)
               && digits_seen != 2'd0 && decoded_now.size() < 2) begin
            emit_char(digits_value);
         end
         start_run(ceu_pkg::MODE_TEXT, 8'h00, 2'd0);
         if (decoded_now.size() == 0) begin
            marker = '0;
            marker.out_last = 1'b1;
            decoded_now.push_back(marker);
         end else begin
            decoded_now[decoded_now.size() - 1].out_last = 1'b1;
         end
      end
      foreach (decoded_now[i]) begin
         expected_chars.push_back(decoded_now[i]);
      end
   endfunction

   function int unsigned sender_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function int receiver_stall();
      int unsigned r;
      if ((results_taken / 250) % 4 == 2) return 0;
      r = $urandom_range(0, 99);
      if (r < 80) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task append_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         str_buf.push_back(s[i]);
      end
   endtask

   // Moves the collected string into the request queue, marking its final byte.
   task queue_string();
      feed_type f;
      bit       calm;
      for (int i = 0; i < str_buf.size(); i++) begin
         calm = (pending_requests.size() / 200) % 4 == 3;
         f.req.in_byte = str_buf[i];
         f.req.in_last = (i == str_buf.size() - 1);
         f.gap_after   = calm ? 0 : sender_gap();
         f.wait_drain  = (i == 0) && drain_next;
         pending_requests.push_back(f);
      end
      drain_next = 1'b0;
      str_buf.delete();
   endtask

   task add_random_token();
      int unsigned r;
      int unsigned n;
      int unsigned v;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         str_buf.push_back(8'($urandom_range(0, 255)));
      end else if (r < 45) begin
         str_buf.push_back(ceu_pkg::CHAR_BSLASH);
         case ($urandom_range(0, 5))
            0: str_buf.push_back(ceu_pkg::CHAR_DQUOTE);
            1: str_buf.push_back(ceu_pkg::CHAR_LOW_N);
            2: str_buf.push_back(ceu_pkg::CHAR_LOW_R);
            3: str_buf.push_back(ceu_pkg::CHAR_LOW_T);
            4: str_buf.push_back(ceu_pkg::CHAR_LOW_E);
            default: str_buf.push_back(ceu_pkg::CHAR_NL);
         endcase
      end else if (r < 62) begin
         str_buf.push_back(ceu_pkg::CHAR_BSLASH);
         n = $urandom_range(1, 3);
         repeat (n) str_buf.push_back(CHR_0 + 8'($urandom_range(0, 7)));
      end else if (r < 80) begin
         str_buf.push_back(ceu_pkg::CHAR_BSLASH);
         str_buf.push_back(ceu_pkg::CHAR_LOW_X);
         n = $urandom_range(0, 2);
         repeat (n) begin
            v = $urandom_range(0, 21);
            if (v < 10) str_buf.push_back(CHR_0 + 8'(v));
            else if (v < 16) str_buf.push_back(CHR_LOW_A + 8'(v - 10));
            else str_buf.push_back(CHR_UP_A + 8'(v - 16));
         end
      end else if (r < 92) begin
         str_buf.push_back(ceu_pkg::CHAR_BSLASH);
         str_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
         str_buf.push_back(ceu_pkg::CHAR_BSLASH);
      end
   endtask

   always @(posedge clock) begin : feed_requests
      feed_type next_feed;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            decode_request(req_data);
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0 &&
                  !(pending_requests[0].wait_drain && expected_chars.size() != 0)) begin
               next_feed = pending_requests.pop_front();
               req_data  <= next_feed.req;
               req_valid <= 1'b1;
               gap_left = next_feed.gap_after;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_results
      ceu_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_taken++;
            if (expected_chars.size() == 0) begin
               report_fault($sformatf("result %0d arrived with nothing expected: %03h",
                  results_taken, rsp_data));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.out_byte !== want.out_byte)
                  report_fault($sformatf("result %0d: out_byte %02h, expected %02h",
                     results_taken, rsp_data.out_byte, want.out_byte));
               if (rsp_data.out_valid !== want.out_valid)
                  report_fault($sformatf("result %0d: out_valid %b, expected %b",
                     results_taken, rsp_data.out_valid, want.out_valid));
               if (rsp_data.out_last !== want.out_last)
                  report_fault($sformatf("result %0d: out_last %b, expected %b",
                     results_taken, rsp_data.out_last, want.out_last));
            end
            // A long hold-off lets the result queue fill and back up the requests.
            if (results_taken == HOLD_AT_FIRST || results_taken == HOLD_AT_LATER) begin
               stall_left = LONG_HOLD;
            end
         end
         if (stall_left == 0) begin
            stall_left = receiver_stall();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin
      int random_count;
      int next_drain_at;
      int tokens;
      start_run(ceu_pkg::MODE_TEXT, 8'h00, 2'd0);

      // Zero and all-ones bytes around every named escape.
      str_buf.push_back(8'h00);
      append_text("\\\"\\n\\r\\t\\e");
      str_buf.push_back(8'hFF);
      queue_string();
      // Octal overflow, an octal run cut by a letter, and a hex escape with no digits.
      append_text("\\777\\1z\\xq");
      queue_string();
      // Escaped nine, then a hex escape left open at the end of the string.
      append_text("\\9\\x");
      queue_string();
      // Backslash-newline and a dangling backslash give only the end marker.
      append_text("\\\n\\");
      queue_string();
      // Two hex digits, then an octal digit flushed by the end of the string.
      append_text("\\xAb\\5");
      queue_string();

      random_count  = 0;
      next_drain_at = 0;
      while (random_count < RANDOM_ITEMS) begin
         if (random_count >= next_drain_at) begin
            drain_next = 1'b1;
            next_drain_at += DRAIN_EVERY;
         end
         tokens = $urandom_range(1, 6);
         repeat (tokens) add_random_token();
         random_count += str_buf.size();
         queue_string();
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (!(pending_requests.size() == 0 && !req_valid && expected_chars.size() == 0))
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_chars.size() != 0) begin
         report_fault($sformatf("%0d results never arrived", expected_chars.size()));
      end
      if (fail_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/ceu_pkg.sv
design/ceu_decode.sv
design/c_escape_unescaper.sv
design/ceu_checker.sv
test/tb_top.sv
